/* sv/tcp_reno_congestion_window_defines.svh */
// ----------------------------------------------------------------------------
// tcp reno congestion window assertion macros
// shared property wrappers clocked on clk_i and disabled in reset
// ----------------------------------------------------------------------------
`ifndef TCP_RENO_CONGESTION_WINDOW_DEFINES_SVH
`define TCP_RENO_CONGESTION_WINDOW_DEFINES_SVH

// plain property check
`define TCPRC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication
`define TCPRC_ASSERT_IMPLIES(label, pre, post, msg) \
  `TCPRC_ASSERT(label, (pre) |-> (post), msg)

// next-cycle implication
`define TCPRC_ASSERT_NEXT(label, pre, post, msg) \
  `TCPRC_ASSERT(label, (pre) |=> (post), msg)

`endif

/* sv/tcprc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcprc_pkg
// types, constants and helpers for the reno congestion window block
// ----------------------------------------------------------------------------
package tcprc_pkg;

  localparam int unsigned AckW    = 32;
  localparam int unsigned WinW    = 16;
  localparam int unsigned DupW    = 4;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [DupW-1:0] DupCountMax   = 4'd15;
  localparam logic [DupW-1:0] DupLimitReset = 4'd3;
  localparam logic [WinW-1:0] HalveFloor    = 16'd2;
  localparam logic [WinW-1:0] RecoveryBonus = 16'd3;
  localparam logic [WinW-1:0] InitWindow    = 16'd1;
  localparam logic [WinW-1:0] InitThreshold = 16'd64;
  localparam logic [WinW-1:0] MaxWindowReset = 16'hFFFF;

  typedef enum logic [CfgIdxW-1:0] {
    RegDupAckLimit = 2'd0,
    RegMaxWindow   = 2'd1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    PhaseSlowStart = 2'd0,
    PhaseAvoid     = 2'd1,
    PhaseRecovery  = 2'd2
  } phase_e;

  typedef struct packed {
    logic [DupW-1:0] dup_limit;
    logic [WinW-1:0] window_cap;
  } cfg_t;

  typedef struct packed {
    logic            retransmit;
    logic [WinW-1:0] window;
    logic [WinW-1:0] threshold;
    phase_e          phase;
  } res_t;

  function automatic logic [WinW-1:0] clamp_window(logic [WinW:0] w, logic [WinW-1:0] cap);
    logic [WinW-1:0] r;
    r = (w > {1'b0, cap}) ? cap : w[WinW-1:0];
    return r;
  endfunction

endpackage

/* sv/tcprc_ack_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcprc_ack_if
// acknowledgment channel, one acknowledgment number per item
// ----------------------------------------------------------------------------
interface tcprc_ack_if;
  logic        valid;
  logic        ready;
  logic [31:0] ack_number;

  modport source (output valid, output ack_number, input ready);
  modport sink (input valid, input ack_number, output ready);
endinterface

/* sv/tcprc_res_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcprc_res_if
// result channel, window state after each acknowledgment
// ----------------------------------------------------------------------------
interface tcprc_res_if;
  logic        valid;
  logic        ready;
  logic        retransmit;
  logic [15:0] window;
  logic [15:0] threshold;
  logic [1:0]  phase;

  modport source (output valid, output retransmit, output window, output threshold,
                  output phase, input ready);
  modport sink (input valid, input retransmit, input window, input threshold,
                input phase, output ready);
endinterface

/* sv/tcp_reno_congestion_window.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcp_reno_congestion_window
// reno congestion window tracker, one acknowledgment number per item
// ----------------------------------------------------------------------------
// usage:
//   ack_i carries received acknowledgment numbers; res_o returns one item per
//   acknowledgment with the retransmit flag, window, threshold and phase
//   after that acknowledgment, in order
//   cfg_we_i/cfg_idx_i/cfg_wdata_i write the duplicate limit (index 0) and
//   the window ceiling (index 1) while no item is in flight
//   an accepted item lands in the input register and is updated in one pass
//   through the engine into the result register: the result becomes valid
//   when the item moves from the input register into the result register,
//   and that move waits while a held result blocks the output
//   throughput is one item per cycle while res_o.ready stays high, since the state is updated in one pass per item
//   reset empties both registers and loads window 1, threshold 64, last ack 0
//   and the register defaults (limit 3, ceiling 65535)
//   when res_o.ready is low the result holds; one more item is taken into
//   the input register, then ack_i.ready drops until the result leaves
// ----------------------------------------------------------------------------
module tcp_reno_congestion_window
  import tcprc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  tcprc_ack_if.sink           ack_i,
  tcprc_res_if.source         res_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  cfg_t            cfg;
  res_t            eng_res;
  res_t            res_q;
  logic [AckW-1:0] ack_q;
  logic            in_valid_q;
  logic            out_valid_q;
  logic            advance;
  logic            step;
  logic            in_fire;

  assign advance     = !out_valid_q || res_o.ready;
  assign step        = in_valid_q && advance;
  assign ack_i.ready = !in_valid_q || advance;
  assign in_fire     = ack_i.valid && ack_i.ready;

  tcprc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  tcprc_engine u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .ack_i  (ack_q),
    .cfg_i  (cfg),
    .res_o  (eng_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      ack_q <= ack_i.ack_number;
    end
    if (step) begin
      res_q <= eng_res;
    end
  end

  assign res_o.valid      = out_valid_q;
  assign res_o.retransmit = res_q.retransmit;
  assign res_o.window     = res_q.window;
  assign res_o.threshold  = res_q.threshold;
  assign res_o.phase      = res_q.phase;

endmodule

/* sv/tcprc_cfg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcprc_cfg
// configuration registers, stored as effective limit and window ceiling
// ----------------------------------------------------------------------------
module tcprc_cfg
  import tcprc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output cfg_t                cfg_o
);

  logic [DupW-1:0] limit_q, limit_d;
  logic [WinW-1:0] cap_q, cap_d;

  always_comb begin
    limit_d = limit_q;
    cap_d   = cap_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegDupAckLimit: begin
          // zero limit acts as one
          limit_d = (cfg_wdata_i[DupW-1:0] == '0) ? DupW'(1) : cfg_wdata_i[DupW-1:0];
        end
        RegMaxWindow: begin
          // ceiling floors at two
          cap_d = (cfg_wdata_i[WinW-1:0] < HalveFloor) ? HalveFloor : cfg_wdata_i[WinW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= DupLimitReset;
      cap_q   <= MaxWindowReset;
    end else begin
      limit_q <= limit_d;
      cap_q   <= cap_d;
    end
  end

  assign cfg_o.dup_limit  = limit_q;
  assign cfg_o.window_cap = cap_q;

endmodule

/* sv/tcprc_engine.sv */
`timescale 1ns / 1ps
`include "tcp_reno_congestion_window_defines.svh"
// ----------------------------------------------------------------------------
// tcprc_engine
// reno state registers and the single-pass update for one acknowledgment
// ----------------------------------------------------------------------------
module tcprc_engine
  import tcprc_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  logic [AckW-1:0] ack_i,
  input  cfg_t            cfg_i,
  output res_t            res_o
);

  logic [AckW-1:0] last_ack_q, last_ack_d;
  logic [DupW-1:0] dup_q, dup_d;
  logic [WinW-1:0] window_q, window_d;
  logic [WinW-1:0] threshold_q, threshold_d;
  logic [WinW-1:0] avoid_q, avoid_d;

  logic            is_dup;
  logic            retx;
  logic [DupW-1:0] dup_inc;
  logic [WinW-1:0] half;
  logic [WinW-1:0] new_thr;
  logic [WinW:0]   win_inc;
  logic [WinW:0]   avoid_inc;

  assign is_dup    = (ack_i == last_ack_q);
  assign dup_inc   = dup_q + DupW'(1);
  assign half      = {1'b0, window_q[WinW-1:1]};
  assign new_thr   = (half < HalveFloor) ? HalveFloor : half;
  assign win_inc   = {1'b0, window_q} + (WinW+1)'(1);
  assign avoid_inc = {1'b0, avoid_q} + (WinW+1)'(1);

  always_comb begin
    dup_d       = dup_q;
    window_d    = window_q;
    threshold_d = threshold_q;
    avoid_d     = avoid_q;
    retx        = 1'b0;
    if (is_dup) begin
      if (dup_q != DupCountMax) begin
        dup_d = dup_inc;
        if (dup_inc == cfg_i.dup_limit) begin
          // fast retransmit, enter recovery
          threshold_d = new_thr;
          window_d    = clamp_window({1'b0, new_thr + RecoveryBonus}, cfg_i.window_cap);
          avoid_d     = '0;
          retx        = 1'b1;
        end
      end
    end else begin
      priority if (dup_q >= cfg_i.dup_limit) begin
        window_d = clamp_window({1'b0, threshold_q}, cfg_i.window_cap);
        avoid_d  = '0;
      end else if (window_q < threshold_q) begin
        window_d = clamp_window(win_inc, cfg_i.window_cap);
        avoid_d  = '0;
      end else begin
        // one segment per full window of acks
        if (avoid_inc >= {1'b0, window_q}) begin
          avoid_d  = '0;
          window_d = clamp_window(win_inc, cfg_i.window_cap);
        end else begin
          avoid_d = avoid_inc[WinW-1:0];
        end
      end
      dup_d = '0;
    end
    last_ack_d = ack_i;
  end

  always_comb begin
    res_o.retransmit = retx;
    res_o.window     = window_d;
    res_o.threshold  = threshold_d;
    priority if (dup_d >= cfg_i.dup_limit) begin
      res_o.phase = PhaseRecovery;
    end else if (window_d < threshold_d) begin
      res_o.phase = PhaseSlowStart;
    end else begin
      res_o.phase = PhaseAvoid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_ack_q  <= '0;
      dup_q       <= '0;
      window_q    <= InitWindow;
      threshold_q <= InitThreshold;
      avoid_q     <= '0;
    end else if (step_i) begin
      last_ack_q  <= last_ack_d;
      dup_q       <= dup_d;
      window_q    <= window_d;
      threshold_q <= threshold_d;
      avoid_q     <= avoid_d;
    end
  end

  `TCPRC_ASSERT(a_window_nonzero, window_q != '0, "congestion window reached zero")
  `TCPRC_ASSERT(a_threshold_floor, threshold_q >= HalveFloor, "threshold below floor")
  `TCPRC_ASSERT_IMPLIES(a_retx_recovery, step_i && res_o.retransmit, res_o.phase == PhaseRecovery, "retransmit outside recovery")
  `TCPRC_ASSERT_NEXT(a_dup_saturates, step_i && is_dup && dup_q == DupCountMax, dup_q == DupCountMax, "duplicate count wrapped")
  `TCPRC_ASSERT_NEXT(a_new_ack_clears, step_i && !is_dup, dup_q == '0 && last_ack_q == $past(ack_i), "new ack did not reset duplicates")

endmodule
